// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define DTFL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion, checked at every edge.
`define DTFL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/dtfl_pkg.sv =====
`default_nettype none

package dtfl_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int SLOT_W        = 6;
  localparam int HANDLE_W      = 16;
  localparam int FLAG_W        = 8;
  localparam int REF_W         = 16;

  localparam logic [REF_W-1:0]  REF_MAX      = 16'hFFFF;
  localparam logic [FLAG_W-1:0] CLOSING_MARK = 8'h01;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_GET   = 3'd1,
    OP_PUT   = 3'd2,
    OP_CLOSE = 3'd3,
    OP_VALID = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [7:0]          fd_index;
    logic [FLAG_W-1:0]   open_flags;
    logic [HANDLE_W-1:0] file_handle;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle_out;
    logic                is_valid;
    logic                take_global_ref;
    logic                drop_global_ref;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dtfl_ctrl.sv =====
`default_nettype none

module dtfl_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dtfl_pkg::ctrl_cmd_t     cmd_o
);
  import dtfl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/dtfl_dp.sv =====
`default_nettype none

module dtfl_dp #(
  parameter int NUM_SLOTS = dtfl_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dtfl_pkg::ctrl_cmd_t cmd_i,
  input  wire dtfl_pkg::req_t      req_i,
  output dtfl_pkg::rsp_t           rsp_o
);
  import dtfl_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int PTR_W = $clog2(NUM_SLOTS + 1);

  logic [HANDLE_W-1:0] handle_mem [NUM_SLOTS];
  logic [FLAG_W-1:0]   flag_mem   [NUM_SLOTS];
  logic [REF_W-1:0]    ref_mem    [NUM_SLOTS];
  logic [PTR_W-1:0]    next_mem   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written_q;

  logic [PTR_W-1:0]    free_head_q, free_head_d;
  req_t                req_q;
  rsp_t                rsp_q, rsp_d;
  logic [IDX_W-1:0]    rd_addr, addr_q;
  logic                ent_written_q;
  logic [HANDLE_W-1:0] rd_handle_q;
  logic [FLAG_W-1:0]   rd_flag_q;
  logic [REF_W-1:0]    rd_ref_q;
  logic [PTR_W-1:0]    rd_next_q;

  logic [HANDLE_W-1:0] cur_handle, wr_handle;
  logic [FLAG_W-1:0]   cur_flag, wr_flag;
  logic [REF_W-1:0]    cur_ref, wr_ref, ref_dec;
  logic [PTR_W-1:0]    cur_next, wr_next;
  logic                wr_en;
  logic                in_range;
  logic                list_empty;

  assign rd_addr = (req_i.op == OP_ADD) ? free_head_q[IDX_W-1:0] : req_i.fd_index[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q         <= req_i;
      addr_q        <= rd_addr;
      ent_written_q <= written_q[rd_addr];
      rd_handle_q   <= handle_mem[rd_addr];
      rd_flag_q     <= flag_mem[rd_addr];
      rd_ref_q      <= ref_mem[rd_addr];
      rd_next_q     <= next_mem[rd_addr];
    end
    if (cmd_i.commit && wr_en) begin
      handle_mem[addr_q] <= wr_handle;
      flag_mem[addr_q]   <= wr_flag;
      ref_mem[addr_q]    <= wr_ref;
      next_mem[addr_q]   <= wr_next;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q   <= '0;
      free_head_q <= '0;
    end else if (cmd_i.commit) begin
      free_head_q <= free_head_d;
      if (wr_en) begin
        written_q[addr_q] <= 1'b1;
      end
    end
  end

  // Untouched entries read as their reset contents.
  assign cur_handle = ent_written_q ? rd_handle_q : '0;
  assign cur_flag   = ent_written_q ? rd_flag_q   : '0;
  assign cur_ref    = ent_written_q ? rd_ref_q    : '0;
  assign cur_next   = ent_written_q ? rd_next_q   : PTR_W'(addr_q) + PTR_W'(1);

  assign in_range   = {1'b0, req_q.fd_index} < 9'(NUM_SLOTS);
  assign list_empty = free_head_q >= PTR_W'(NUM_SLOTS);
  assign ref_dec    = (cur_ref != '0) ? cur_ref - REF_W'(1) : '0;

  always_comb begin
    rsp_d       = '0;
    rsp_d.status = ST_OK;
    free_head_d = free_head_q;
    wr_en       = 1'b0;
    wr_handle   = cur_handle;
    wr_flag     = cur_flag;
    wr_ref      = cur_ref;
    wr_next     = cur_next;
    case (req_q.op)
      OP_ADD: begin
        if (list_empty) begin
          rsp_d.status = ST_FULL;
        end else if (req_q.file_handle == '0) begin
          rsp_d.status = ST_BAD;
        end else begin
          wr_en                 = 1'b1;
          wr_handle             = req_q.file_handle;
          wr_flag               = req_q.open_flags;
          wr_ref                = REF_W'(1);
          free_head_d           = cur_next;
          rsp_d.slot            = SLOT_W'(addr_q);
          rsp_d.take_global_ref = 1'b1;
        end
      end
      OP_VALID: begin
        if (!in_range) begin
          rsp_d.status = ST_BAD;
        end else begin
          rsp_d.is_valid = (cur_handle != '0);
        end
      end
      OP_GET, OP_PUT, OP_CLOSE: begin
        if (!in_range || cur_handle == '0) begin
          rsp_d.status = ST_BAD;
        end else if (req_q.op == OP_GET) begin
          wr_en            = 1'b1;
          wr_ref           = (cur_ref == REF_MAX) ? cur_ref : cur_ref + REF_W'(1);
          rsp_d.handle_out = cur_handle;
        end else if (req_q.op == OP_CLOSE && (cur_flag & CLOSING_MARK) != '0) begin
          rsp_d.status = ST_OK;
        end else begin
          wr_en  = 1'b1;
          wr_ref = ref_dec;
          if (req_q.op == OP_CLOSE) begin
            wr_flag = cur_flag | CLOSING_MARK;
          end
          if (ref_dec == '0) begin
            wr_handle             = '0;
            wr_flag               = '0;
            wr_next               = free_head_q;
            free_head_d           = PTR_W'(addr_q);
            rsp_d.handle_out      = cur_handle;
            rsp_d.drop_global_ref = 1'b1;
          end
        end
      end
      default: begin
        rsp_d.status = ST_BAD;
      end
    endcase
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/descriptor_table_free_list_unit.sv =====
`default_nettype none

// Descriptor table with a linked free list and a 16-bit reference count per slot.
// One request is taken at a time. In the accept cycle the addressed entry (the
// free head for add) is read from the table memory into a register; in the
// execute state the entry and the free head are updated and the result is
// loaded into the output register. The execute state holds while an earlier
// result is not taken. A new request is taken while the previous result waits.
// Reset clears the whole table at once through per-slot written bits; no
// clearing pass follows reset.
module descriptor_table_free_list_unit #(
  parameter int NUM_SLOTS = dtfl_pkg::NUM_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dtfl_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dtfl_pkg::rsp_t      out_rsp_o
);
  import dtfl_pkg::*;

  ctrl_cmd_t cmd;

  dtfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dtfl_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/dtfl_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module dtfl_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire dtfl_pkg::req_t in_req_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire dtfl_pkg::rsp_t out_rsp_o
);
  import dtfl_pkg::*;

  `DTFL_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))

  `DTFL_ASSERT(a_one_at_a_time, clk_i, rst_ni,
    in_valid_i && in_ready_o |=> !in_ready_o)

  `DTFL_ASSERT(a_take_ok, clk_i, rst_ni,
    out_valid_o && out_rsp_o.take_global_ref |->
      out_rsp_o.status == ST_OK && !out_rsp_o.drop_global_ref)

  `DTFL_ASSERT(a_drop_has_handle, clk_i, rst_ni,
    out_valid_o && out_rsp_o.drop_global_ref |->
      out_rsp_o.handle_out != '0 && out_rsp_o.status == ST_OK)

endmodule

bind descriptor_table_free_list_unit dtfl_checker u_dtfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// ===== test/descriptor_table_checker.sv =====
`timescale 1ns / 1ps

module descriptor_table_checker
  import dtfl_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  rsp_t out_rsp_i,
  output int   failures_o,
  output int   pending_o
);

  logic [HANDLE_W-1:0] handle_mem [NUM_SLOTS];
  logic [FLAG_W-1:0]   flag_mem   [NUM_SLOTS];
  logic [REF_W-1:0]    refcnt_mem [NUM_SLOTS];
  int                  link_mem   [NUM_SLOTS];
  int                  free_head;
  rsp_t                rsp_expected_q [$];

  // Apply one request to the shadow table and return the response it causes.
  function automatic rsp_t table_op_result(req_t r);
    rsp_t p;
    int   s;
    p = '0;
    p.status = ST_OK;
    if (r.op == OP_ADD) begin
      if (free_head >= NUM_SLOTS) begin
        p.status = ST_FULL;
      end else if (r.file_handle == '0) begin
        p.status = ST_BAD;
      end else begin
        s = free_head;
        free_head = link_mem[s];
        refcnt_mem[s] = 1;
        flag_mem[s] = r.open_flags;
        handle_mem[s] = r.file_handle;
        p.slot = SLOT_W'(s);
        p.take_global_ref = 1'b1;
      end
      return p;
    end
    if (r.op > OP_VALID || r.fd_index >= NUM_SLOTS) begin
      p.status = ST_BAD;
      return p;
    end
    s = r.fd_index;
    if (r.op == OP_VALID) begin
      p.is_valid = (handle_mem[s] != '0);
      return p;
    end
    if (handle_mem[s] == '0) begin
      p.status = ST_BAD;
      return p;
    end
    if (r.op == OP_GET) begin
      if (refcnt_mem[s] < REF_MAX) refcnt_mem[s] = refcnt_mem[s] + 1'b1;
      p.handle_out = handle_mem[s];
      return p;
    end
    if (r.op == OP_CLOSE) begin
      if ((flag_mem[s] & CLOSING_MARK) != '0) return p;
      flag_mem[s] = flag_mem[s] | CLOSING_MARK;
    end
    if (refcnt_mem[s] != '0) refcnt_mem[s] = refcnt_mem[s] - 1'b1;
    if (refcnt_mem[s] == '0) begin
      p.handle_out = handle_mem[s];
      p.drop_global_ref = 1'b1;
      handle_mem[s] = '0;
      flag_mem[s] = '0;
      link_mem[s] = free_head;
      free_head = s;
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        handle_mem[i] = '0;
        flag_mem[i] = '0;
        refcnt_mem[i] = '0;
        link_mem[i] = i + 1;
      end
      free_head = 0;
      rsp_expected_q.delete();
      pending_o = 0;
      failures_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (rsp_expected_q.size() == 0) begin
          $error("unexpected response: status %0d slot %0d handle %h",
                 out_rsp_i.status, out_rsp_i.slot, out_rsp_i.handle_out);
          failures_o++;
        end else begin
          want = rsp_expected_q.pop_front();
          if (out_rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_i.status);
            failures_o++;
          end
          if (out_rsp_i.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_rsp_i.slot);
            failures_o++;
          end
          if (out_rsp_i.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, got %h", want.handle_out,
                   out_rsp_i.handle_out);
            failures_o++;
          end
          if (out_rsp_i.is_valid !== want.is_valid) begin
            $error("is_valid: expected %b, got %b", want.is_valid, out_rsp_i.is_valid);
            failures_o++;
          end
          if (out_rsp_i.take_global_ref !== want.take_global_ref) begin
            $error("take_global_ref: expected %b, got %b", want.take_global_ref,
                   out_rsp_i.take_global_ref);
            failures_o++;
          end
          if (out_rsp_i.drop_global_ref !== want.drop_global_ref) begin
            $error("drop_global_ref: expected %b, got %b", want.drop_global_ref,
                   out_rsp_i.drop_global_ref);
            failures_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) rsp_expected_q.push_back(table_op_result(in_req_i));
      pending_o = rsp_expected_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dtfl_pkg::*;

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SEG_ITEMS   = 150;
  localparam int NUM_SEGS    = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int OP_MAX_CODE = (1 << $bits(op_e)) - 1;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;
  int   failures;
  int   pending;
  int   cycle_cnt;
  bit   idle_on;
  bit   hold_rsp;
  bit   hold_done;

  descriptor_table_free_list_unit #(.NUM_SLOTS(NUM_SLOTS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  descriptor_table_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_i   (out_rsp_o),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, int idx, int flags, int handle);
    req_t r;
    r.op = op;
    r.fd_index = 8'(idx);
    r.open_flags = FLAG_W'(flags);
    r.file_handle = HANDLE_W'(handle);
    return r;
  endfunction

  function automatic req_t rand_req(bit fill_bias);
    int   w;
    int   idx;
    int   handle;
    op_e  op;
    w = $urandom_range(0, 99);
    if (fill_bias) begin
      if (w < 60) op = OP_ADD;
      else if (w < 75) op = OP_GET;
      else if (w < 85) op = OP_PUT;
      else if (w < 90) op = OP_CLOSE;
      else if (w < 98) op = OP_VALID;
      else op = op_e'($urandom_range(OP_VALID + 1, OP_MAX_CODE));
    end else begin
      if (w < 10) op = OP_ADD;
      else if (w < 20) op = OP_GET;
      else if (w < 60) op = OP_PUT;
      else if (w < 90) op = OP_CLOSE;
      else if (w < 98) op = OP_VALID;
      else op = op_e'($urandom_range(OP_VALID + 1, OP_MAX_CODE));
    end
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                      : $urandom_range(0, NUM_SLOTS - 1);
    handle = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 65535);
    return make_req(op, idx, $urandom_range(0, 255), handle);
  endfunction

  // Drop valid for random idle bursts, then offer the request until accepted.
  task automatic send_req(req_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    idle_on = 1'b1;
    hold_rsp = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_req(make_req(OP_VALID, 0, 0, 0));
    send_req(make_req(OP_GET, 0, 0, 0));
    send_req(make_req(OP_PUT, 0, 0, 0));
    send_req(make_req(OP_CLOSE, 0, 0, 0));
    send_req(make_req(OP_ADD, 0, 8'h00, 16'h0000));
    send_req(make_req(OP_ADD, 255, 8'hFF, 16'hFFFF));
    send_req(make_req(OP_ADD, 0, 8'h00, 16'h0001));
    send_req(make_req(OP_ADD, 0, 8'hFE, 16'h8000));
    send_req(make_req(OP_VALID, 0, 0, 0));
    send_req(make_req(OP_VALID, NUM_SLOTS - 1, 0, 0));
    send_req(make_req(OP_VALID, 255, 0, 0));
    send_req(make_req(OP_GET, NUM_SLOTS, 0, 0));
    send_req(make_req(OP_GET, 0, 0, 0));
    send_req(make_req(OP_CLOSE, 0, 0, 0));
    send_req(make_req(OP_PUT, 0, 0, 0));
    send_req(make_req(OP_PUT, 0, 0, 0));
    send_req(make_req(OP_CLOSE, 1, 0, 0));
    send_req(make_req(OP_ADD, 0, 8'h55, 16'h00AA));
    send_req(make_req(op_e'(OP_VALID + 1), 3, 0, 0));
    send_req(make_req(op_e'(OP_MAX_CODE), 3, 0, 0));
    send_req(make_req(OP_PUT, 255, 0, 0));

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      idle_on = (seg < NUM_SEGS - 1);
      if (seg == 1) hold_rsp = 1'b1;
      repeat (SEG_ITEMS) send_req(rand_req(seg % 2 == 0));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
